[src/rtic_pkg.sv]
// ----------------------------------------------------------------------------
// rtic_pkg
// Shared types and constants for the inset rectangle clamp.
// ----------------------------------------------------------------------------
package rtic_pkg;

	localparam int COORD_W = 21;
	localparam int VP_W    = 13;
	localparam int DIV_W   = 16;
	localparam int IDX_W   = 2;

	localparam logic [IDX_W-1:0] REG_VP_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_VP_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_INSET_DIV = 2'd2;

	localparam logic [VP_W-1:0]  RST_VP_WIDTH  = 13'd1920;
	localparam logic [VP_W-1:0]  RST_VP_HEIGHT = 13'd1080;
	localparam logic [DIV_W-1:0] RST_INSET_DIV = 16'd2560;

	typedef enum logic [1:0] {
		MG_LOAD,
		MG_RUN,
		MG_IDLE
	} mg_state_t;

endpackage

[src/ray_to_inset_rectangle_clamp.sv]
// ----------------------------------------------------------------------------
// ray_to_inset_rectangle_clamp
// Moves an off-rectangle target point onto the inset rectangle along the ray
// from the viewport center; points inside pass through.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------
//   item in  | start & !busy          | target_x, target_y
//   result   | done (one cycle)       | indicator_x, indicator_y, was_clamped
//   config   | cfg_valid & cfg_ready  | cfg_index, cfg_data
//
// One item per cycle while busy is low; each result passes through the
// bit-per-stage pipelined divider (FRAC_BITS + 14 stages).
// The margin is found by a bit-serial divider of FRAC_BITS + 21 steps that
// runs after reset and after each height or divisor write; busy and
// !cfg_ready hold meanwhile.
// The receiver cannot stall; the pipeline always advances.
// ----------------------------------------------------------------------------
module ray_to_inset_rectangle_clamp import rtic_pkg::*; #(
	parameter int FRAC_BITS = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic signed [COORD_W-1:0]  target_x,
	input  logic signed [COORD_W-1:0]  target_y,
	output logic                       done,
	output logic signed [COORD_W-1:0]  indicator_x,
	output logic signed [COORD_W-1:0]  indicator_y,
	output logic                       was_clamped,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [IDX_W-1:0]           cfg_index,
	input  logic [DIV_W-1:0]           cfg_data
);

	localparam int WPIX = VP_W + FRAC_BITS;
	localparam int MW   = VP_W + FRAC_BITS + 8;
	localparam int CW   = MW + 3;
	localparam int DMW  = ((WPIX > COORD_W) ? WPIX : COORD_W) + 1;
	localparam int NMW  = MW + 1;
	localparam int PW   = DMW + NMW;
	localparam int NW   = PW + 1;
	localparam int DW   = DMW + 1;
	localparam int QB   = WPIX + 1;
	localparam int CNTW = $clog2(MW);
	localparam int LAT  = QB + 4;

	localparam logic signed [CW-1:0] CMAX = CW'((64'sd1 <<< (COORD_W - 1)) - 1);
	localparam logic signed [CW-1:0] CMIN = -CW'(64'sd1 <<< (COORD_W - 1));

	typedef struct packed {
		logic                     vld;
		logic signed [COORD_W-1:0] tx;
		logic signed [COORD_W-1:0] ty;
		logic                     outside;
		logic                     xok;
		logic                     yok;
		logic                     ylt;
		logic                     negx;
		logic                     negy;
		logic signed [CW-1:0]     ex;
		logic signed [CW-1:0]     ey;
	} sb_t;

	// configuration and margin
	logic [VP_W-1:0]  vw_q, vh_q;
	logic [DIV_W-1:0] idiv_q;
	mg_state_t        mg_state_q, mg_state_d;
	logic [MW-1:0]    dvd_q, quo_q;
	logic [DIV_W-1:0] rem_q;
	logic [CNTW-1:0]  cnt_q;
	logic             mg_load, mg_step, cfg_we, mg_kick;
	logic [DIV_W-1:0] dv;
	logic [DIV_W:0]   remx;
	logic             rbit;

	assign cfg_we  = cfg_valid && cfg_ready;
	assign mg_kick = cfg_we && (cfg_index == REG_VP_HEIGHT || cfg_index == REG_INSET_DIV);
	assign dv      = (idiv_q == '0) ? DIV_W'(1) : idiv_q;
	assign remx    = {rem_q, dvd_q[MW-1]};
	assign rbit    = (remx >= {1'b0, dv});

	always_comb begin
		mg_state_d = mg_state_q;
		case (mg_state_q)
			MG_LOAD: mg_state_d = MG_RUN;
			MG_RUN:  if (cnt_q == CNTW'(MW - 1)) mg_state_d = MG_IDLE;
			MG_IDLE: if (mg_kick) mg_state_d = MG_LOAD;
			default: mg_state_d = MG_LOAD;
		endcase
	end

	always_comb begin
		mg_load   = 1'b0;
		mg_step   = 1'b0;
		busy      = 1'b1;
		cfg_ready = 1'b0;
		case (mg_state_q)
			MG_LOAD: mg_load = 1'b1;
			MG_RUN:  mg_step = 1'b1;
			MG_IDLE: begin
				busy      = 1'b0;
				cfg_ready = 1'b1;
			end
			default: mg_load = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vw_q       <= RST_VP_WIDTH;
			vh_q       <= RST_VP_HEIGHT;
			idiv_q     <= RST_INSET_DIV;
			mg_state_q <= MG_LOAD;
			cnt_q      <= '0;
		end else begin
			mg_state_q <= mg_state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_VP_WIDTH:  vw_q   <= cfg_data[VP_W-1:0];
					REG_VP_HEIGHT: vh_q   <= cfg_data[VP_W-1:0];
					REG_INSET_DIV: idiv_q <= cfg_data;
					default:       ;
				endcase
			end
			if (mg_load) cnt_q <= '0;
			else if (mg_step) cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mg_load) begin
			dvd_q <= {vh_q, {(FRAC_BITS + 8){1'b0}}};
			rem_q <= '0;
			quo_q <= '0;
		end else if (mg_step) begin
			dvd_q <= {dvd_q[MW-2:0], 1'b0};
			rem_q <= rbit ? DIV_W'(remx - {1'b0, dv}) : remx[DIV_W-1:0];
			quo_q <= {quo_q[MW-2:0], rbit};
		end
	end

	// geometry shared by stage 1 and the final stage
	logic signed [CW-1:0] wf, hf, cx, cy, mg, minx, maxx, miny, maxy;
	assign wf   = signed'(CW'(vw_q)) <<< FRAC_BITS;
	assign hf   = signed'(CW'(vh_q)) <<< FRAC_BITS;
	assign cx   = wf >>> 1;
	assign cy   = hf >>> 1;
	assign mg   = signed'(CW'(quo_q));
	assign minx = mg;
	assign maxx = wf - mg;
	assign miny = mg;
	assign maxy = hf - mg;

	// stage 1: offsets, edges, magnitudes
	logic signed [CW-1:0] txe, tye, dx, dy, exc, eyc, nx, ny;
	logic signed [CW-1:0] adxf, adyf, anxf, anyf;
	sb_t sb_s1, sb_s2;
	logic [DMW-1:0] adx_s1, ady_s1, adx_s2, ady_s2;
	logic [NMW-1:0] anx_s1, any_s1;
	logic           dxnz_s1, dynz_s1, dxnz_s2, dynz_s2;

	assign txe  = CW'(target_x);
	assign tye  = CW'(target_y);
	assign dx   = txe - cx;
	assign dy   = tye - cy;
	assign exc  = dx[CW-1] ? minx : maxx;
	assign eyc  = dy[CW-1] ? miny : maxy;
	assign nx   = exc - cx;
	assign ny   = eyc - cy;
	assign adxf = dx[CW-1] ? -dx : dx;
	assign adyf = dy[CW-1] ? -dy : dy;
	assign anxf = nx[CW-1] ? -nx : nx;
	assign anyf = ny[CW-1] ? -ny : ny;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_s1 <= '0;
			sb_s2 <= '0;
		end else begin
			sb_s1.vld     <= start && !busy;
			sb_s1.tx      <= target_x;
			sb_s1.ty      <= target_y;
			sb_s1.outside <= (txe < minx) || (txe > maxx) || (tye < miny) || (tye > maxy);
			sb_s1.xok     <= 1'b0;
			sb_s1.yok     <= 1'b0;
			sb_s1.ylt     <= 1'b0;
			sb_s1.negx    <= dy[CW-1] ^ nx[CW-1] ^ dx[CW-1];
			sb_s1.negy    <= dx[CW-1] ^ ny[CW-1] ^ dy[CW-1];
			sb_s1.ex      <= exc;
			sb_s1.ey      <= eyc;
			sb_s2         <= sb_s1;
		end
	end

	always_ff @(posedge clk) begin
		adx_s1        <= adxf[DMW-1:0];
		ady_s1        <= adyf[DMW-1:0];
		anx_s1        <= anxf[NMW-1:0];
		any_s1        <= anyf[NMW-1:0];
		dxnz_s1       <= (dx != '0);
		dynz_s1       <= (dy != '0);
	end

	// stage 2: products
	logic [PW-1:0] px_s2, py_s2;
	always_ff @(posedge clk) begin
		px_s2   <= PW'(ady_s1) * PW'(anx_s1);
		py_s2   <= PW'(adx_s1) * PW'(any_s1);
		adx_s2  <= adx_s1;
		ady_s2  <= ady_s1;
		dxnz_s2 <= dxnz_s1;
		dynz_s2 <= dynz_s1;
	end

	// stage 3 and divider: rounded quotients, one bit a stage
	logic [NW-1:0] nxn, nyn, dxl, dyl;
	assign nxn = {px_s2, 1'b0} + NW'(adx_s2);
	assign nyn = {py_s2, 1'b0} + NW'(ady_s2);
	assign dxl = NW'({adx_s2, 1'b0}) << QB;
	assign dyl = NW'({ady_s2, 1'b0}) << QB;

	sb_t           sb_sx  [QB+1];
	logic [NW-1:0] remx_sx[QB+1];
	logic [NW-1:0] remy_sx[QB+1];
	logic [DW-1:0] dx_sx  [QB+1];
	logic [DW-1:0] dy_sx  [QB+1];
	logic [QB-1:0] qx_sx  [QB+1];
	logic [QB-1:0] qy_sx  [QB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_sx[0] <= '0;
		end else begin
			sb_sx[0].vld     <= sb_s2.vld;
			sb_sx[0].tx      <= sb_s2.tx;
			sb_sx[0].ty      <= sb_s2.ty;
			sb_sx[0].outside <= sb_s2.outside;
			sb_sx[0].xok     <= dxnz_s2 && (nxn < dxl);
			sb_sx[0].yok     <= dynz_s2 && (nyn < dyl);
			sb_sx[0].ylt     <= py_s2 < px_s2;
			sb_sx[0].negx    <= sb_s2.negx;
			sb_sx[0].negy    <= sb_s2.negy;
			sb_sx[0].ex      <= sb_s2.ex;
			sb_sx[0].ey      <= sb_s2.ey;
		end
	end

	always_ff @(posedge clk) begin
		remx_sx[0]       <= nxn;
		remy_sx[0]       <= nyn;
		dx_sx[0]         <= {adx_s2, 1'b0};
		dy_sx[0]         <= {ady_s2, 1'b0};
		qx_sx[0]         <= '0;
		qy_sx[0]         <= '0;
	end

	for (genvar k = 0; k < QB; k++) begin : g_div
		localparam int SH = QB - 1 - k;
		logic [NW-1:0] dxs, dys;
		logic          gx, gy;
		assign dxs = NW'(dx_sx[k]) << SH;
		assign dys = NW'(dy_sx[k]) << SH;
		assign gx  = remx_sx[k] >= dxs;
		assign gy  = remy_sx[k] >= dys;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sb_sx[k+1] <= '0;
			else         sb_sx[k+1] <= sb_sx[k];
		end

		always_ff @(posedge clk) begin
			remx_sx[k+1] <= gx ? remx_sx[k] - dxs : remx_sx[k];
			remy_sx[k+1] <= gy ? remy_sx[k] - dys : remy_sx[k];
			dx_sx[k+1]   <= dx_sx[k];
			dy_sx[k+1]   <= dy_sx[k];
			qx_sx[k+1]   <= qx_sx[k] | (QB'(gx) << SH);
			qy_sx[k+1]   <= qy_sx[k] | (QB'(gy) << SH);
		end
	end

	// final stage: cut points, span test, nearest edge, saturation
	sb_t                  sf;
	logic signed [CW-1:0] qxs, qys, ycut, xcut, rx, ry;
	logic                 xv, yv, clamp;

	assign sf   = sb_sx[QB];
	assign qxs  = signed'(CW'(qx_sx[QB]));
	assign qys  = signed'(CW'(qy_sx[QB]));
	assign ycut = cy + (sf.negx ? -qxs : qxs);
	assign xcut = cx + (sf.negy ? -qys : qys);
	assign xv   = sf.outside && sf.xok && (ycut >= miny) && (ycut <= maxy);
	assign yv   = sf.outside && sf.yok && (xcut >= minx) && (xcut <= maxx);

	always_comb begin
		rx    = CW'(sf.tx);
		ry    = CW'(sf.ty);
		clamp = 1'b0;
		if (xv && !(yv && sf.ylt)) begin
			rx    = sf.ex;
			ry    = ycut;
			clamp = 1'b1;
		end else if (yv) begin
			rx    = xcut;
			ry    = sf.ey;
			clamp = 1'b1;
		end
	end

	logic signed [CW-1:0] rxs, rys;
	assign rxs = (rx > CMAX) ? CMAX : ((rx < CMIN) ? CMIN : rx);
	assign rys = (ry > CMAX) ? CMAX : ((ry < CMIN) ? CMIN : ry);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done        <= 1'b0;
			was_clamped <= 1'b0;
		end else begin
			done        <= sf.vld;
			was_clamped <= sf.vld && clamp;
		end
	end

	always_ff @(posedge clk) begin
		indicator_x <= rxs[COORD_W-1:0];
		indicator_y <= rys[COORD_W-1:0];
	end

	a_clamp_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		was_clamped |-> done) else $error("clamp flag without result");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done) else $error("result missing after start");

	a_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready == !busy) else $error("config ready and busy disagree");

endmodule
